@@ design/fcsws_pkg.sv @@
// shared types and constants for the four channel stepper wave sequencer
package fcsws_pkg;

    localparam int COIL_W      = 4;
    localparam int SHOWN       = 4;
    localparam int COUNT_W     = 8;
    localparam int PHASE_W     = 2;
    localparam int INDEX_W     = 2;
    localparam int LEVELS_W    = COIL_W * SHOWN;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] DIV_RESET = 8'd7;

    // register word index of the step divider
    localparam logic REG_STEP_DIVIDER = 1'b0;

    typedef enum logic
    {
        ACT_TICK = 1'b0,
        ACT_SET  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        DIR_FWD  = 2'd0,
        DIR_BWD  = 2'd1,
        DIR_STOP = 2'd2,
        DIR_HOLD = 2'd3
    } dir_t;

    // control from the top level to one motor channel
    typedef struct packed
    {
        logic tick;
        logic set;
        logic enable;
        dir_t direction;
    } motor_ctrl_t;

    // status from one motor channel: coil levels after the transfer
    typedef struct packed
    {
        logic [COIL_W-1:0] coils;
        logic              stepped;
    } motor_stat_t;

endpackage

@@ design/fcsws_in_if.sv @@
// command channel: tick or set-motor transfers
interface fcsws_in_if
    import fcsws_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [INDEX_W-1:0] motor_sel;
    logic               enable;
    logic [1:0]         direction;

    modport source (output valid, output action, output motor_sel, output enable,
                    output direction, input ready);
    modport sink   (input valid, input action, input motor_sel, input enable,
                    input direction, output ready);
endinterface

@@ design/fcsws_out_if.sv @@
// result channel: coil levels and stepped mask
interface fcsws_out_if
    import fcsws_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LEVELS_W-1:0] coil_levels;
    logic [SHOWN-1:0]    stepped_mask;

    modport source (output valid, output coil_levels, output stepped_mask, input ready);
    modport sink   (input valid, input coil_levels, input stepped_mask, output ready);
endinterface

@@ design/fcsws_regs.sv @@
// apb register block holding the shared step divider
module fcsws_regs
    import fcsws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    divider
);
    logic [COUNT_W-1:0] divider_reg;
    logic [COUNT_W-1:0] divider_next;
    logic               hit;

    assign pready = 1'b1;
    // word index sits above the byte offset
    assign hit    = (paddr[APB_ADDR_W-1] == REG_STEP_DIVIDER);

    // register write on the access phase
    always_comb
    begin
        divider_next = divider_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            divider_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= DIV_RESET;
        end
        else
        begin
            divider_reg <= divider_next;
        end
    end

    // read back
    assign prdata  = hit ? {{(APB_DATA_W-COUNT_W){1'b0}}, divider_reg} : '0;
    assign divider = divider_reg;
endmodule

@@ design/fcsws_motor.sv @@
// one motor channel: counter, phase, mode and wave-drive coil state
module fcsws_motor
    import fcsws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  motor_ctrl_t        ctrl,
    input  logic [COUNT_W-1:0] divider,
    output motor_stat_t        stat
);
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               active_reg;
    logic               active_next;
    dir_t               dir_reg;
    dir_t               dir_next;
    logic [COIL_W-1:0]  coils_reg;
    logic [COIL_W-1:0]  coils_next;
    logic               step_due;
    logic [PHASE_W-1:0] clr_idx;
    logic [PHASE_W-1:0] set_idx;
    logic [COIL_W-1:0]  stepped_coils;

    // step condition and the coil pair that changes
    assign step_due = active_reg && ((dir_reg == DIR_FWD) || (dir_reg == DIR_BWD))
                      && (count_reg >= divider);
    assign clr_idx  = (dir_reg == DIR_FWD) ? phase_reg - 2'd1 : 2'd0 - phase_reg;
    assign set_idx  = (dir_reg == DIR_FWD) ? phase_reg : ~phase_reg;

    always_comb
    begin
        stepped_coils          = coils_reg;
        stepped_coils[clr_idx] = 1'b0;
        stepped_coils[set_idx] = 1'b1;
    end

    // next state for set and tick transfers
    always_comb
    begin
        count_next  = count_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        dir_next    = dir_reg;
        coils_next  = coils_reg;
        if (ctrl.set)
        begin
            active_next = ctrl.enable;
            dir_next    = ctrl.direction;
        end
        else if (ctrl.tick && active_reg)
        begin
            if (step_due)
            begin
                count_next = COUNT_W'(1);
                phase_next = phase_reg + 2'd1;
                coils_next = stepped_coils;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                if (dir_reg == DIR_STOP)
                begin
                    coils_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            phase_reg  <= '0;
            active_reg <= 1'b1;
            dir_reg    <= DIR_BWD;
            coils_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            dir_reg    <= dir_next;
            coils_reg  <= coils_next;
        end
    end

    assign stat.coils   = coils_next;
    assign stat.stepped = ctrl.tick && step_due;
endmodule

@@ design/four_channel_stepper_wave_sequencer_core.sv @@
// path: an accepted transfer is held in the input register, then its result in the result register
// throughput: one command per cycle while the result channel does not stall
// a command is taken while a finished result still waits on the output, if the input register is empty
// reset: asynchronous, active low; divider 7, all motors enabled backward
// reset also clears counters, phases and coils; no results pending
module four_channel_stepper_wave_sequencer_core
    import fcsws_pkg::*;
#(
    parameter int NUM_MOTORS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    fcsws_in_if.sink              in_ch,
    fcsws_out_if.source           out_ch
);
    logic                in_valid_reg;
    logic                in_valid_next;
    action_t             action_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                enable_reg;
    dir_t                direction_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LEVELS_W-1:0] levels_reg;
    logic [SHOWN-1:0]    mask_reg;
    logic                out_free;
    logic                fire;
    logic [COUNT_W-1:0]  divider;
    logic [LEVELS_W-1:0] levels_pack;
    logic [SHOWN-1:0]    mask_pack;
    motor_ctrl_t         ctrl   [NUM_MOTORS];
    motor_stat_t         stat   [NUM_MOTORS];

    fcsws_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .divider (divider)
    );

    // handshake between input and result registers
    assign out_free       = !out_valid_reg || out_ch.ready;
    assign fire           = in_valid_reg && out_free;
    assign in_ch.ready    = !in_valid_reg || out_free;
    assign in_valid_next  = (in_ch.valid && in_ch.ready) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            action_reg    <= action_t'(in_ch.action);
            index_reg     <= in_ch.motor_sel;
            enable_reg    <= in_ch.enable;
            direction_reg <= dir_t'(in_ch.direction);
        end
    end

    // motor channels
    for (genvar i = 0; i < NUM_MOTORS; i++)
    begin : g_motor
        if (i < SHOWN)
        begin : g_addr
            assign ctrl[i].set = fire && (action_reg == ACT_SET)
                                 && (index_reg == INDEX_W'(i));
        end
        else
        begin : g_noaddr
            assign ctrl[i].set = 1'b0;
        end
        assign ctrl[i].tick      = fire && (action_reg == ACT_TICK);
        assign ctrl[i].enable    = enable_reg;
        assign ctrl[i].direction = direction_reg;

        fcsws_motor u_motor
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[i]),
            .divider (divider),
            .stat    (stat[i])
        );
    end

    // pack the first four motors into the result fields
    for (genvar k = 0; k < SHOWN; k++)
    begin : g_pack
        if (k < NUM_MOTORS)
        begin : g_built
            assign levels_pack[k*COIL_W +: COIL_W] = stat[k].coils;
            assign mask_pack[k]                    = stat[k].stepped;
        end
        else
        begin : g_absent
            assign levels_pack[k*COIL_W +: COIL_W] = '0;
            assign mask_pack[k]                    = 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            levels_reg <= levels_pack;
            mask_reg   <= mask_pack;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.coil_levels  = levels_reg;
    assign out_ch.stepped_mask = mask_reg;

    // set transfers never report a step
    a_set_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (action_reg == ACT_SET)) |-> (mask_pack == '0))
        else $error("stepped mask set on a set transfer");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without a held result");

    // a processed command always produces a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed command lost its result");

    // a pending command is kept until processed
    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("pending command dropped");
endmodule

@@ test/tb.sv @@
// self-checking testbench for the four channel stepper wave sequencer core
`timescale 1ns / 100ps

module tb;
    import fcsws_pkg::*;

    localparam int MOTORS      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;

    // receiver ready patterns
    typedef enum int
    {
        RX_ALWAYS = 0,
        RX_RANDOM = 1,
        RX_BURSTS = 2
    } rx_pattern_t;

    // coil levels and stepped mask as seen on the result channel
    typedef struct packed
    {
        logic [LEVELS_W-1:0] levels;
        logic [SHOWN-1:0]    mask;
    } coil_state_t;

    // wave drive predictor plus queue of pending coil states
    class coil_scoreboard;
        logic [COUNT_W-1:0] divider;
        logic [COUNT_W-1:0] tick_cnt [MOTORS];
        logic [PHASE_W-1:0] phase [MOTORS];
        logic               active [MOTORS];
        dir_t               mode [MOTORS];
        logic [COIL_W-1:0]  coils [MOTORS];
        coil_state_t        expected_q [$];
        int                 errors;

        function new();
            divider = DIV_RESET;
            errors = 0;
            for (int i = 0; i < MOTORS; i++)
            begin
                tick_cnt[i] = '0;
                phase[i] = '0;
                active[i] = 1'b1;
                mode[i] = DIR_BWD;
                coils[i] = '0;
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void set_divider(input logic [COUNT_W-1:0] value);
            divider = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the motor model by one accepted command transfer
        function void note_command(input action_t act, input logic [INDEX_W-1:0] idx,
                                   input logic en, input dir_t dir);
            logic [SHOWN-1:0]   mask;
            logic [PHASE_W-1:0] clr_bit;
            logic [PHASE_W-1:0] set_bit;
            coil_state_t        res;
            mask = '0;
            if (act == ACT_SET)
            begin
                active[idx] = en;
                mode[idx] = dir;
            end
            else
            begin
                for (int i = 0; i < MOTORS; i++)
                begin
                    if (active[i])
                    begin
                        // step when the counter has reached the divider
                        if ((mode[i] == DIR_FWD || mode[i] == DIR_BWD) && tick_cnt[i] >= divider)
                        begin
                            tick_cnt[i] = '0;
                            if (mode[i] == DIR_FWD)
                            begin
                                clr_bit = phase[i] + 2'd3;
                                set_bit = phase[i];
                            end
                            else
                            begin
                                clr_bit = 2'd0 - phase[i];
                                set_bit = 2'd3 - phase[i];
                            end
                            coils[i][clr_bit] = 1'b0;
                            coils[i][set_bit] = 1'b1;
                            phase[i] = phase[i] + 2'd1;
                            mask[i] = 1'b1;
                        end
                        else if (mode[i] == DIR_STOP)
                        begin
                            coils[i] = '0;
                        end
                        tick_cnt[i] = tick_cnt[i] + 8'd1;
                    end
                end
            end
            res.mask = mask;
            for (int i = 0; i < SHOWN; i++)
            begin
                res.levels[i*COIL_W +: COIL_W] = coils[i];
            end
            expected_q.push_back(res);
        endfunction

        // compare one result transfer with the oldest pending state
        task check_result(input logic [LEVELS_W-1:0] levels, input logic [SHOWN-1:0] mask);
            coil_state_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result levels %h mask %b", levels, mask));
            end
            else
            begin
                want = expected_q.pop_front();
                if (levels !== want.levels)
                    report($sformatf("coil_levels %h, want %h", levels, want.levels));
                if (mask !== want.mask)
                    report($sformatf("stepped_mask %b, want %b", mask, want.mask));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fcsws_in_if  cmd_if ();
    fcsws_out_if res_if ();

    coil_scoreboard     coil_sb;
    int                 burst_left;
    bit                 gaps_on;
    rx_pattern_t        rx_mode;
    int                 stall_left;
    logic [COUNT_W-1:0] div_plan [PHASES];
    int                 item_plan [PHASES];
    int                 set_plan [PHASES];

    four_channel_stepper_wave_sequencer_core #(.NUM_MOTORS(MOTORS)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (cmd_if),
        .out_ch  (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // result receiver with its own stall pattern
    always @(negedge clk)
    begin
        unique case (rx_mode)
            RX_ALWAYS: res_if.ready = 1'b1;
            RX_RANDOM: res_if.ready = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    res_if.ready = 1'b0;
                    stall_left--;
                end
                else
                begin
                    res_if.ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            coil_sb.check_result(res_if.coil_levels, res_if.stepped_mask);
    end

    // one command transfer, with a random gap between bursts when gaps are enabled
    task send_command(input action_t act, input logic [INDEX_W-1:0] idx,
                      input logic en, input dir_t dir);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                cmd_if.valid = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        cmd_if.valid = 1'b1;
        cmd_if.action = act;
        cmd_if.motor_sel = idx;
        cmd_if.enable = en;
        cmd_if.direction = dir;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        coil_sb.note_command(act, idx, en, dir);
        @(negedge clk);
    endtask

    // mostly ticks, with set commands at the given percentage
    task send_random(input int count, input int set_pct);
        action_t              act;
        logic [INDEX_W-1:0]   idx;
        logic                 en;
        dir_t                 dir;
        for (int n = 0; n < count; n++)
        begin
            act = ($urandom_range(1, 100) <= set_pct) ? ACT_SET : ACT_TICK;
            idx = INDEX_W'($urandom_range(0, 3));
            en = ($urandom_range(0, 3) != 0);
            dir = dir_t'($urandom_range(0, 3));
            send_command(act, idx, en, dir);
        end
    endtask

    // wait for every pending result
    task drain();
        cmd_if.valid = 1'b0;
        while (coil_sb.pending() != 0)
            @(negedge clk);
    endtask

    // write the step divider, then read it back
    task program_divider(input logic [COUNT_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_W'(4 * REG_STEP_DIVIDER);
        pwdata = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        coil_sb.set_divider(value);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_DATA_W'(value))
            coil_sb.report($sformatf("step_divider read %h, want %h", prdata, value));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin
        coil_sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.action = ACT_TICK;
        cmd_if.motor_sel = '0;
        cmd_if.enable = 1'b0;
        cmd_if.direction = DIR_FWD;
        res_if.ready = 1'b0;
        rx_mode = RX_ALWAYS;
        stall_left = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset divider: backward motors first step on the eighth tick
        rx_mode = RX_RANDOM;
        repeat (9) send_command(ACT_TICK, 2'd0, 1'b0, DIR_FWD);
        send_command(ACT_SET, 2'd0, 1'b1, DIR_FWD);
        send_command(ACT_SET, 2'd1, 1'b1, DIR_BWD);
        send_command(ACT_SET, 2'd2, 1'b1, DIR_STOP);
        send_command(ACT_SET, 2'd3, 1'b1, DIR_HOLD);

        // divider zero: moving motors step on every tick, then disable motors and change directions
        drain();
        program_divider(8'd0);
        repeat (4) send_command(ACT_TICK, 2'd3, 1'b1, DIR_HOLD);
        send_command(ACT_SET, 2'd1, 1'b0, DIR_FWD);
        send_command(ACT_SET, 2'd2, 1'b1, DIR_FWD);
        repeat (3) send_command(ACT_TICK, 2'd0, 1'b0, DIR_FWD);
        send_command(ACT_SET, 2'd3, 1'b0, DIR_HOLD);
        send_command(ACT_SET, 2'd0, 1'b1, DIR_BWD);
        repeat (2) send_command(ACT_TICK, 2'd3, 1'b1, DIR_STOP);

        // random phases over a range of divider settings
        div_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd7};
        div_plan[3] = COUNT_W'($urandom_range(2, 15));
        div_plan[4] = COUNT_W'($urandom_range(0, 255));
        item_plan = '{100, 250, 90, 90, 90, 80};
        set_plan = '{20, 5, 20, 20, 20, 20};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            program_divider(div_plan[ph]);
            gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_mode = (ph == 0) ? RX_ALWAYS : rx_pattern_t'($urandom_range(0, 2));
            burst_left = 0;
            send_random(item_plan[ph], set_plan[ph]);
        end

        drain();
        repeat (4) @(posedge clk);
        if (coil_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
